// File: rtl/core/ces_pkg.sv
`default_nettype none

package ces_pkg;

  // item kinds on the input channel
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOW    = 2'd0,
    CFG_HIGH   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } ces_cfg_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
  } ces_in_t;

  typedef struct packed {
    logic edge_res;
    logic frame_end;
  } ces_out_t;

  // one window position inside the line rings
  typedef struct packed {
    logic        valid;
    logic        border;
    logic        tail;
    logic [1:0]  slot;
    logic [11:0] col;
  } ces_pos_t;

  // classified beat handed from the front to the back
  typedef struct packed {
    logic       wr;
    logic [7:0] pixel;
    ces_pos_t   wpos;
    ces_pos_t   gpos;
    ces_pos_t   spos;
    ces_pos_t   dpos;
  } ces_item_t;

  // row offset of a 3x3 neighbour, raster order without the centre
  function automatic logic [1:0] nb_dr(input logic [2:0] idx);
    logic [1:0] r;
    case (idx)
      3'd0, 3'd1, 3'd2: r = 2'b11;
      3'd3, 3'd4:       r = 2'b00;
      default:          r = 2'b01;
    endcase
    return r;
  endfunction

  // column offset of a 3x3 neighbour
  function automatic logic [1:0] nb_dc(input logic [2:0] idx);
    logic [1:0] c;
    case (idx)
      3'd0, 3'd3, 3'd5: c = 2'b11;
      3'd1, 3'd6:       c = 2'b00;
      default:          c = 2'b01;
    endcase
    return c;
  endfunction

  // neighbours compared during suppression for each direction bin
  function automatic logic [2:0] sup_nbr(input logic [1:0] dir, input logic second);
    logic [2:0] n;
    case (dir)
      2'd0:    n = second ? 3'd3 : 3'd4;
      2'd1:    n = second ? 3'd2 : 3'd5;
      2'd2:    n = second ? 3'd6 : 3'd1;
      default: n = second ? 3'd7 : 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ces_queue.sv
`default_nettype none

module ces_queue import ces_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  ces_item_t      item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output ces_item_t      item_o
);

  ces_item_t  mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ces_front.sv
`default_nettype none

module ces_front import ces_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  ces_in_t          in_data_i,
  input  wire logic [12:0] width_i,
  input  wire logic [15:0] height_i,
  input  wire logic        restart_i,
  output logic             push_o,
  output ces_item_t        item_o,
  input  wire logic        full_i
);

  logic [16:0] row_q;
  logic [11:0] col_q;
  logic [16:0] row;
  logic [11:0] col;
  logic [12:0] col_inc;
  logic        rst_pos;
  logic        drain;
  logic        ignore;
  logic        accept;
  ces_pos_t    gp;
  ces_pos_t    sp;
  ces_pos_t    dp;

  // position k*W + k places behind (r, c), classified against the frame
  function automatic ces_pos_t calc_pos(input logic [16:0] r, input logic [11:0] c,
                                        input logic [12:0] w, input logic [15:0] h,
                                        input logic [1:0] k);
    logic signed [18:0] pr;
    logic [12:0]        pc;
    logic [17:0]        hm1;
    ces_pos_t           p;
    hm1 = {2'b00, h} - 18'd1;
    if ({1'b0, c} >= {11'd0, k}) begin
      pr = $signed({2'b00, r}) - $signed({17'd0, k});
      pc = {1'b0, c} - {11'd0, k};
    end else begin
      pr = $signed({2'b00, r}) - $signed({17'd0, k}) - 19'sd1;
      pc = {1'b0, c} + w - {11'd0, k};
    end
    p.valid  = !pr[18] && (pr[17:0] < {2'b00, h});
    p.border = (pr == 19'sd0) || (pc == 13'd0) || (pr[17:0] == hm1) || (pc == w - 13'd1);
    p.tail   = (pr[17:0] == hm1) && (pc == w - 13'd1);
    p.slot   = pr[1:0];
    p.col    = pc[11:0];
    return p;
  endfunction

  // restart on a stale position, then classify the beat
  always_comb begin
    rst_pos = ({1'b0, col_q} >= width_i) || ({1'b0, row_q} > ({2'b00, height_i} + 18'd4));
    row     = rst_pos ? 17'd0 : row_q;
    col     = rst_pos ? 12'd0 : col_q;
    drain   = (row >= {1'b0, height_i});
    ignore  = !drain && (in_data_i.kind == KIND_FLUSH);
    col_inc = {1'b0, col} + 13'd1;
    gp      = calc_pos(row, col, width_i, height_i, 2'd1);
    sp      = calc_pos(row, col, width_i, height_i, 2'd2);
    dp      = calc_pos(row, col, width_i, height_i, 2'd3);
  end

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept && !ignore;

  always_comb begin
    item_o.wr          = !drain;
    item_o.pixel       = in_data_i.pixel;
    item_o.wpos.valid  = 1'b1;
    item_o.wpos.border = 1'b0;
    item_o.wpos.tail   = 1'b0;
    item_o.wpos.slot   = row[1:0];
    item_o.wpos.col    = col;
    item_o.gpos        = gp;
    item_o.spos        = sp;
    item_o.dpos        = dp;
  end

  // stream position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 17'd0;
      col_q <= 12'd0;
    end else if (restart_i) begin
      row_q <= 17'd0;
      col_q <= 12'd0;
    end else if (accept) begin
      if (ignore) begin
        row_q <= row;
        col_q <= col;
      end else if (dp.valid && dp.tail) begin
        row_q <= 17'd0;
        col_q <= 12'd0;
      end else if (col_inc == width_i) begin
        row_q <= row + 17'd1;
        col_q <= 12'd0;
      end else begin
        row_q <= row;
        col_q <= col_inc[11:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ces_back.sv
`default_nettype none

module ces_back import ces_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  ces_item_t       item_i,
  output logic            pop_o,
  input  wire logic [9:0] low_i,
  input  wire logic [9:0] high_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output ces_out_t        out_data_o
);

  localparam int DEPTH = 4 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [11:0] {
    ST_IDLE = 12'h001,
    ST_WPIX = 12'h002,
    ST_GRD  = 12'h004,
    ST_GA   = 12'h008,
    ST_GB   = 12'h010,
    ST_GC   = 12'h020,
    ST_SQRT = 12'h040,
    ST_GWR  = 12'h080,
    ST_SUP  = 12'h100,
    ST_SWR  = 12'h200,
    ST_DEC  = 12'h400,
    ST_OUT  = 12'h800
  } st_e;

  st_e         state_q, state_d;
  st_e         nxt_g, nxt_s, nxt_d;
  ces_item_t   ent_q;
  logic [3:0]  k_q;
  logic [7:0]  pix_q [8];
  logic [7:0]  ax_q, ay_q;
  logic        gxp_q, gyp_q, ygt_q;
  logic [15:0] ax2_q, ay2_q, u2_q;
  logic [17:0] t2_q;
  logic [16:0] v_q;
  logic [1:0]  gdir_q, sdir_q;
  logic [8:0]  root_q;
  logic [8:0]  scen_q, snba_q, sval_q, dcen_q;
  logic        strong_q;
  logic        out_valid_q;
  ces_out_t    out_q;
  logic        out_busy;
  logic        out_load;

  // line rings
  logic [7:0]  pix_mem [DEPTH];
  logic [8:0]  mag_mem [DEPTH];
  logic [1:0]  dir_mem [DEPTH];
  logic [8:0]  sup_mem [DEPTH];
  logic [7:0]  pix_rd_q;
  logic [8:0]  mag_rd_q;
  logic [1:0]  dir_rd_q;
  logic [8:0]  sup_rd_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] pix_wa, g_wa, s_wa;
  logic        pix_we, g_we, s_we;

  // gradient datapath
  logic [9:0]         gxa, gxb, gya, gyb;
  logic signed [10:0] gx, gy;
  logic [10:0]        agx, agy;
  logic [8:0]         tsum;
  logic [7:0]         udif;
  logic [16:0]        two_ax2;
  logic [8:0]         trial;
  logic [17:0]        trial_sq;
  logic [2:0]         nidx;

  function automatic logic [AW-1:0] mk_addr(input logic [1:0] slot, input logic [11:0] col,
                                            input logic [1:0] dr, input logic [1:0] dc);
    logic [1:0]  s2;
    logic [11:0] c2;
    s2 = slot + dr;
    c2 = col + {{10{dc[1]}}, dc};
    return AW'(s2) * AW'(MAX_WIDTH) + AW'(c2);
  endfunction

  assign out_busy    = out_valid_q && out_stall_i;
  assign out_load    = (state_q == ST_OUT) && ent_q.dpos.valid && !out_busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sequencer
  always_comb begin
    nxt_d   = (ent_q.dpos.valid && !ent_q.dpos.border) ? ST_DEC : ST_OUT;
    nxt_s   = ent_q.spos.valid ? (ent_q.spos.border ? ST_SWR : ST_SUP) : nxt_d;
    nxt_g   = ent_q.gpos.valid ? (ent_q.gpos.border ? ST_GWR : ST_GRD) : nxt_s;
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_WPIX;
        end
      end
      ST_WPIX: state_d = nxt_g;
      ST_GRD:  if (k_q == 4'd8) state_d = ST_GA;
      ST_GA:   state_d = ST_GB;
      ST_GB:   state_d = ST_GC;
      ST_GC:   state_d = ST_SQRT;
      ST_SQRT: if (k_q == 4'd8) state_d = ST_GWR;
      ST_GWR:  state_d = nxt_s;
      ST_SUP:  if (k_q == 4'd3) state_d = ST_SWR;
      ST_SWR:  state_d = nxt_d;
      ST_DEC:  if (k_q == 4'd9) state_d = ST_OUT;
      ST_OUT:  if (!(ent_q.dpos.valid && out_busy)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // read address for the step in progress
  always_comb begin
    nidx = k_q[2:0] - 3'd1;
    case (state_q)
      ST_GRD:
        rd_addr = mk_addr(ent_q.gpos.slot, ent_q.gpos.col, nb_dr(k_q[2:0]), nb_dc(k_q[2:0]));
      ST_SUP: begin
        if (k_q == 4'd0) begin
          rd_addr = mk_addr(ent_q.spos.slot, ent_q.spos.col, 2'b00, 2'b00);
        end else if (k_q == 4'd1) begin
          rd_addr = mk_addr(ent_q.spos.slot, ent_q.spos.col,
                            nb_dr(sup_nbr(dir_rd_q, 1'b0)), nb_dc(sup_nbr(dir_rd_q, 1'b0)));
        end else begin
          rd_addr = mk_addr(ent_q.spos.slot, ent_q.spos.col,
                            nb_dr(sup_nbr(sdir_q, 1'b1)), nb_dc(sup_nbr(sdir_q, 1'b1)));
        end
      end
      ST_DEC: begin
        if (k_q == 4'd0) begin
          rd_addr = mk_addr(ent_q.dpos.slot, ent_q.dpos.col, 2'b00, 2'b00);
        end else begin
          rd_addr = mk_addr(ent_q.dpos.slot, ent_q.dpos.col, nb_dr(nidx), nb_dc(nidx));
        end
      end
      default: rd_addr = mk_addr(ent_q.gpos.slot, ent_q.gpos.col, 2'b00, 2'b00);
    endcase
  end

  // write ports
  always_comb begin
    pix_wa = mk_addr(ent_q.wpos.slot, ent_q.wpos.col, 2'b00, 2'b00);
    g_wa   = mk_addr(ent_q.gpos.slot, ent_q.gpos.col, 2'b00, 2'b00);
    s_wa   = mk_addr(ent_q.spos.slot, ent_q.spos.col, 2'b00, 2'b00);
    pix_we = (state_q == ST_WPIX) && ent_q.wr;
    g_we   = (state_q == ST_GWR);
    s_we   = (state_q == ST_SWR);
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[pix_wa] <= ent_q.pixel;
    end
    pix_rd_q <= pix_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      mag_mem[g_wa] <= ent_q.gpos.border ? 9'd0 : root_q;
      dir_mem[g_wa] <= ent_q.gpos.border ? 2'd0 : gdir_q;
    end
    mag_rd_q <= mag_mem[rd_addr];
    dir_rd_q <= dir_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      sup_mem[s_wa] <= ent_q.spos.border ? 9'd0 : sval_q;
    end
    sup_rd_q <= sup_mem[rd_addr];
  end

  // sobel sums, magnitudes truncated toward zero
  always_comb begin
    gxa = {2'b00, pix_q[0]} + {1'b0, pix_q[3], 1'b0} + {2'b00, pix_q[5]};
    gxb = {2'b00, pix_q[2]} + {1'b0, pix_q[4], 1'b0} + {2'b00, pix_q[7]};
    gya = {2'b00, pix_q[5]} + {1'b0, pix_q[6], 1'b0} + {2'b00, pix_q[7]};
    gyb = {2'b00, pix_q[0]} + {1'b0, pix_q[1], 1'b0} + {2'b00, pix_q[2]};
    gx  = $signed({1'b0, gxa}) - $signed({1'b0, gxb});
    gy  = $signed({1'b0, gya}) - $signed({1'b0, gyb});
    agx = gx[10] ? 11'(-gx) : 11'(gx);
    agy = gy[10] ? 11'(-gy) : 11'(gy);
    tsum    = {1'b0, ax_q} + {1'b0, ay_q};
    udif    = ay_q - ax_q;
    two_ax2 = {ax2_q, 1'b0};
    trial    = root_q | (9'd1 << (4'd8 - k_q));
    trial_sq = {9'd0, trial} * {9'd0, trial};
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= 4'd0;
      out_valid_q <= 1'b0;
      strong_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          k_q      <= 4'd0;
          strong_q <= 1'b0;
          if (!empty_i) begin
            ent_q <= item_i;
          end
        end
        ST_GRD: begin
          if (k_q != 4'd0) begin
            pix_q[nidx] <= pix_rd_q;
          end
          k_q <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
        end
        ST_GA: begin
          ax_q  <= agx[9:2];
          ay_q  <= agy[9:2];
          gxp_q <= (gx > 11'sd3);
          gyp_q <= (gy > 11'sd3);
        end
        ST_GB: begin
          ax2_q <= {8'd0, ax_q} * {8'd0, ax_q};
          ay2_q <= {8'd0, ay_q} * {8'd0, ay_q};
          t2_q  <= {9'd0, tsum} * {9'd0, tsum};
          u2_q  <= {8'd0, udif} * {8'd0, udif};
          ygt_q <= (ay_q > ax_q);
        end
        ST_GC: begin
          v_q    <= {1'b0, ax2_q} + {1'b0, ay2_q};
          root_q <= 9'd0;
          k_q    <= 4'd0;
          if (t2_q <= {1'b0, two_ax2}) begin
            gdir_q <= 2'd0;
          end else if (ygt_q && ({1'b0, u2_q} > two_ax2)) begin
            gdir_q <= 2'd2;
          end else if (gxp_q == gyp_q) begin
            gdir_q <= 2'd1;
          end else begin
            gdir_q <= 2'd3;
          end
        end
        // one result bit per step
        ST_SQRT: begin
          if (trial_sq <= {1'b0, v_q}) begin
            root_q <= trial;
          end
          k_q <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
        end
        ST_SUP: begin
          if (k_q == 4'd1) begin
            sdir_q <= dir_rd_q;
            scen_q <= mag_rd_q;
          end
          if (k_q == 4'd2) begin
            snba_q <= mag_rd_q;
          end
          if (k_q == 4'd3) begin
            sval_q <= ((scen_q < snba_q) || (scen_q < mag_rd_q)) ? 9'd0 : scen_q;
          end
          k_q <= (k_q == 4'd3) ? 4'd0 : k_q + 4'd1;
        end
        // centre then the eight neighbours
        ST_DEC: begin
          if (k_q == 4'd1) begin
            dcen_q <= sup_rd_q;
          end
          if ((k_q != 4'd0) && ({1'b0, sup_rd_q} >= high_i)) begin
            strong_q <= 1'b1;
          end
          k_q <= (k_q == 4'd9) ? 4'd0 : k_q + 4'd1;
        end
        ST_OUT: begin
          if (out_load) begin
            out_q.frame_end <= ent_q.dpos.tail;
            out_q.edge_res  <= !ent_q.dpos.border &&
                               (({1'b0, dcen_q} >= high_i) ||
                                (({1'b0, dcen_q} >= low_i) && strong_q));
          end
        end
        default: begin
          k_q <= k_q;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/canny_edge_stream_top.sv
`default_nettype none

// Streaming Canny edge detector on pre-smoothed 8-bit pixels in raster order.
// The front takes one beat per clock while the queue is not full, tracks the
// stream position and sorts each beat into pixel write, gradient, suppression
// and hysteresis positions; a two-entry queue feeds the back, which works on
// one beat at a time. The line memories share one read address and are read
// one window tap per cycle (8 taps for Sobel, 3 for suppression, 9 for
// hysteresis) and the 9-bit magnitude square root is formed one bit per cycle;
// border positions skip their arithmetic. A flush beat outside the drain is
// dropped in the front. The result for raster position p appears with the beat
// that moves the stream to p + 3*W + 3; after the last pixel, 3*W + 3 beats of
// flush (or pixels) drain the remaining results, the last one flagged with
// frame_end. Border pixels are always background. Writing width or height
// restarts the frame.
module canny_edge_stream_top import ces_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  ces_in_t          in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ces_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [9:0]  low_q;
  logic [9:0]  high_q;
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [12:0] eff_w;
  logic [15:0] eff_h;
  logic        cfg_wr;
  logic        restart;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop;
  ces_item_t   push_item;
  ces_item_t   head_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_wr && ((cfg_addr_i == CFG_WIDTH) || (cfg_addr_i == CFG_HEIGHT));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= 10'd0;
      high_q   <= 10'd1023;
      width_q  <= 11'd640;
      height_q <= 16'd480;
    end else if (cfg_wr) begin
      case (cfg_addr_i)
        CFG_LOW:    low_q    <= cfg_data_i[9:0];
        CFG_HIGH:   high_q   <= cfg_data_i[9:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        default:    low_q    <= low_q;
      endcase
    end
  end

  // clamp the frame geometry
  always_comb begin
    if (width_q < 11'd3) begin
      eff_w = 13'd3;
    end else if ({2'b00, width_q} > 13'(MAX_WIDTH)) begin
      eff_w = 13'(MAX_WIDTH);
    end else begin
      eff_w = {2'b00, width_q};
    end
    eff_h = (height_q < 16'd3) ? 16'd3 : height_q;
  end

  ces_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .width_i    (eff_w),
    .height_i   (eff_h),
    .restart_i  (restart),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  ces_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  ces_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .low_i       (low_q),
    .high_i      (high_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
